/* hw/rtl/bbf_pkg.sv */
package bbf_pkg;

    localparam int MAX_BLOCKS      = 1024;
    localparam int WORDS_PER_BLOCK = 8;
    localparam int WORD_W          = 32;
    localparam int ROW_W           = WORDS_PER_BLOCK * WORD_W;
    localparam int POS_W           = 5;
    localparam int SALT_SHIFT      = 27;

    // largest log2 whose power of two fits in the store
    localparam int MAX_LOG2 = $clog2(MAX_BLOCKS + 1) - 1;
    localparam int ROWS     = 2 ** MAX_LOG2;
    localparam int BLK_W    = (MAX_LOG2 > 0) ? MAX_LOG2 : 1;

    localparam int          CFG_W     = 4;
    localparam logic [3:0]  CFG_RESET = 4'd10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] SALTS = {
        32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
        32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
    };

    typedef struct packed {
        logic                                  opcode;
        logic [BLK_W-1:0]                      block;
        logic [WORDS_PER_BLOCK-1:0][POS_W-1:0] pos;
    } t_req;

endpackage

/* hw/rtl/bbf_front.sv */
module bbf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [63:0]                 i_hash_value,
    input  logic                        i_cfg_wr_en,
    input  logic [bbf_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_clearing,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output bbf_pkg::t_req               o_q_data
);

    logic [bbf_pkg::CFG_W-1:0]  r_log2;
    logic                       r_valid;
    logic                       n_valid;
    logic                       r_opcode;
    logic [bbf_pkg::BLK_W-1:0]  r_block;
    logic [31:0]                r_key;
    logic [bbf_pkg::CFG_W-1:0]  eff_log2;
    logic [31:0]                blk_mask;
    logic                       accept;
    logic [31:0]                prod [bbf_pkg::WORDS_PER_BLOCK];

    assign o_in_stall = i_clearing || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;

    assign eff_log2 = (r_log2 > bbf_pkg::CFG_W'(bbf_pkg::MAX_LOG2)) ?
                      bbf_pkg::CFG_W'(bbf_pkg::MAX_LOG2) : r_log2;
    assign blk_mask = (32'd1 << eff_log2) - 32'd1;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    // one salt multiply per lane, top bits pick the bit in the word
    always_comb begin
        o_q_data.opcode = r_opcode;
        o_q_data.block  = r_block;
        for (int l = 0; l < bbf_pkg::WORDS_PER_BLOCK; l++) begin
            prod[l]        = r_key * bbf_pkg::SALTS[l];
            o_q_data.pos[l] = prod[l][31 -: bbf_pkg::POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2  <= bbf_pkg::CFG_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_wr_en) begin
                r_log2 <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= i_opcode;
            r_block  <= bbf_pkg::BLK_W'(i_hash_value[63:32] & blk_mask);
            r_key    <= i_hash_value[31:0];
        end
    end

endmodule

/* hw/rtl/bbf_queue.sv */
module bbf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbf_pkg::t_req   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bbf_pkg::t_req   o_data
);

    bbf_pkg::t_req  r_entry [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_entry[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/bbf_back.sv */
module bbf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output logic            o_clearing,
    input  logic            i_q_empty,
    input  bbf_pkg::t_req   i_q_data,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_maybe_present
);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [bbf_pkg::BLK_W-1:0]      r_clr_addr;
    logic [bbf_pkg::ROW_W-1:0]      mem [bbf_pkg::ROWS];
    logic [bbf_pkg::ROW_W-1:0]      r_rd_data;
    bbf_pkg::t_req                  r_req;
    logic                           r_out_valid;
    logic                           r_present;
    logic [bbf_pkg::ROW_W-1:0]      lane_mask;
    logic                           wr_en;
    logic [bbf_pkg::BLK_W-1:0]      wr_addr;
    logic [bbf_pkg::ROW_W-1:0]      wr_data;
    logic                           hit;

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_maybe_present = r_present;
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        lane_mask = '0;
        for (int l = 0; l < bbf_pkg::WORDS_PER_BLOCK; l++) begin
            lane_mask[l*bbf_pkg::WORD_W +: bbf_pkg::WORD_W] =
                bbf_pkg::WORD_W'(1) << r_req.pos[l];
        end
    end

    assign hit = ((r_rd_data & lane_mask) == lane_mask);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_req.block;
        wr_data = r_rd_data | lane_mask;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (r_clr_addr == bbf_pkg::BLK_W'(bbf_pkg::ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_q_pop) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                wr_en   = (r_req.opcode == bbf_pkg::OP_INSERT);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + bbf_pkg::BLK_W'(1);
            end
            if (r_state == S_UPDATE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req     <= i_q_data;
            r_rd_data <= mem[i_q_data.block];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (r_state == S_UPDATE) begin
            r_present <= (r_req.opcode == bbf_pkg::OP_QUERY) && hit;
        end
    end

endmodule

/* hw/rtl/split_block_bloom_filter.sv */
// path from an accepted request to its result: front register, queue, block row read,
// update and output register
// a block row's read-modify-write ends before the back end pops the next request
// reset: synchronous, active low; afterwards a clearing pass zeroes the block store,
// with o_in_stall high until it is done
module split_block_bloom_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [63:0]                 i_hash_value,
    input  logic                        i_cfg_wr_en,
    input  logic [bbf_pkg::CFG_W-1:0]   i_cfg_wr_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_maybe_present
);

    logic           clearing;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    bbf_pkg::t_req  q_wr_data;
    bbf_pkg::t_req  q_rd_data;

    bbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_hash_value  (i_hash_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_clearing    (clearing),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wr_data)
    );

    bbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    bbf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_clearing      (clearing),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rd_data),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_maybe_present (o_maybe_present)
    );

endmodule

/* hw/rtl/bbf_checker.sv */
module bbf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_maybe_present
);

    logic [3:0] r_pending;
    logic [3:0] n_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc) begin
            n_pending = r_pending + 4'd1;
        end else if (out_acc && !in_acc) begin
            n_pending = r_pending - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // results never outrun requests
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 4'd0))
        else $error("result without outstanding request");

    // at most front, queue, back and output stages in flight
    a_bounded_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd5)
        else $error("too many requests in flight");

    // clearing pass blocks requests straight after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

endmodule

bind split_block_bloom_filter bbf_checker u_bbf_checker (.*);
